@@ hdl/kna_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the kernel neighborhood address generator.
// Used by every module under hdl; depends on nothing.
package kna_pkg;

  localparam int DIMS        = 3;
  localparam int CW          = 16;  // coordinate width
  localparam int ADDR_W      = 48;
  localparam int EXT_W       = 17;
  localparam int STRIDE_W    = 2 * EXT_W;
  localparam int OFS_W       = 5;
  localparam int MAX_OFFSETS = 27;
  localparam int CFG_W       = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int OP_W        = 3;

  typedef enum logic [OP_W-1:0] {
    OP_FWD   = 3'd0,
    OP_BWD   = 3'd1,
    OP_BEGIN = 3'd2,
    OP_END   = 3'd3,
    OP_JUMP  = 3'd4
  } kna_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROI_LOW     = 3'd0,
    REG_ROI_HIGH    = 3'd1,
    REG_EXTENT_MID  = 3'd2,
    REG_EXTENT_FAST = 3'd3,
    REG_WINDOW_BACK = 3'd4,
    REG_WINDOW_FWD  = 3'd5,
    REG_SCAN_ORDER  = 3'd6
  } kna_reg_e;

  // scan order codes, named fastest to slowest dimension
  typedef enum logic [2:0] {
    SCAN_210 = 3'd0,
    SCAN_201 = 3'd1,
    SCAN_120 = 3'd2,
    SCAN_102 = 3'd3,
    SCAN_021 = 3'd4,
    SCAN_012 = 3'd5
  } kna_scan_e;

  typedef logic [DIMS-1:0][CW-1:0] kna_coord_t;

  typedef struct packed {
    kna_coord_t              lo;
    kna_coord_t              hi;
    logic [DIMS-1:0]         back;
    logic [DIMS-1:0]         fwd;
    logic [2:0]              scan;
    logic [EXT_W-1:0]        fast;
    logic [STRIDE_W-1:0]     stride0;
  } kna_cfg_t;

  typedef struct packed {
    logic [OFS_W-1:0] k;
    kna_coord_t       nb;
    logic             at_end;
    logic             last;
  } kna_res_t;

  // Dimension visited at scan position pos (0 is fastest).
  function automatic logic [1:0] scan_dim(logic [2:0] order, logic [1:0] pos);
    logic [2:0][1:0] perm;
    case (order)
      SCAN_201: perm = {2'd1, 2'd0, 2'd2};
      SCAN_120: perm = {2'd0, 2'd2, 2'd1};
      SCAN_102: perm = {2'd2, 2'd0, 2'd1};
      SCAN_021: perm = {2'd1, 2'd2, 2'd0};
      SCAN_012: perm = {2'd2, 2'd1, 2'd0};
      default:  perm = {2'd0, 2'd1, 2'd2};
    endcase
    return perm[pos];
  endfunction

endpackage

@@ hdl/kernel_neighborhood_address_gen.sv @@
`timescale 1ns / 1ps
// A command word taken loads the center and the offset walker; each result word then passes
// the s1 register and the result register. Throughput: one result word per cycle while
// res_ready_i does not stall; a command emits 1 to 27 words (the kernel size, or one end
// marker) and the next command is taken in the cycle its last word is made.
// Reset (rst_ni low, asynchronous): center at zero, end flag clear, pipeline empty,
// configuration at region 0..0, extents 1, no window, scan order 2,1,0.
module kernel_neighborhood_address_gen (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [kna_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [kna_pkg::CFG_W-1:0]          cfg_wdata_i,
  // command channel
  input  logic                               cmd_valid_i,
  output logic                               cmd_ready_o,
  input  logic [kna_pkg::OP_W-1:0]           op_i,
  input  logic [kna_pkg::CW-1:0]             jump_c0_i,
  input  logic [kna_pkg::CW-1:0]             jump_c1_i,
  input  logic [kna_pkg::CW-1:0]             jump_c2_i,
  // result channel
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output logic [kna_pkg::OFS_W-1:0]          offset_number_o,
  output logic [kna_pkg::CW-1:0]             neighbor_c0_o,
  output logic [kna_pkg::CW-1:0]             neighbor_c1_o,
  output logic [kna_pkg::CW-1:0]             neighbor_c2_o,
  output logic [kna_pkg::ADDR_W-1:0]         linear_address_o,
  output logic                               at_end_o,
  output logic                               last_o
);
  import kna_pkg::*;

  // configuration registers
  logic [CFG_W-1:0]    roi_low_q, roi_high_q;
  logic [EXT_W-1:0]    extent_mid_q, extent_fast_q;
  logic [DIMS-1:0]     window_back_q, window_fwd_q;
  logic [2:0]          scan_order_q;
  logic [STRIDE_W-1:0] stride0_q;   // dim0 stride, registered from the product of the extents

  kna_cfg_t   cfg;
  kna_coord_t jump, center, nb;
  logic       cmd_fire, end_flag, gen_ready, advance, s1_valid;
  kna_res_t   s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roi_low_q     <= '0;
      roi_high_q    <= '0;
      extent_mid_q  <= EXT_W'(1);
      extent_fast_q <= EXT_W'(1);
      window_back_q <= '0;
      window_fwd_q  <= '0;
      scan_order_q  <= SCAN_210;
      stride0_q     <= STRIDE_W'(1);
    end else begin
      stride0_q <= extent_mid_q * extent_fast_q;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ROI_LOW:     roi_low_q     <= cfg_wdata_i;
          REG_ROI_HIGH:    roi_high_q    <= cfg_wdata_i;
          REG_EXTENT_MID:  extent_mid_q  <= cfg_wdata_i[EXT_W-1:0];
          REG_EXTENT_FAST: extent_fast_q <= cfg_wdata_i[EXT_W-1:0];
          REG_WINDOW_BACK: window_back_q <= cfg_wdata_i[DIMS-1:0];
          REG_WINDOW_FWD:  window_fwd_q  <= cfg_wdata_i[DIMS-1:0];
          REG_SCAN_ORDER:  scan_order_q  <= cfg_wdata_i[2:0];
          default: ;  // drop writes past the register list
        endcase
      end
    end
  end

  // bounds are packed dim0 in the low bits, same as the coordinate array
  assign cfg.lo      = roi_low_q;
  assign cfg.hi      = roi_high_q;
  assign cfg.back    = window_back_q;
  assign cfg.fwd     = window_fwd_q;
  assign cfg.scan    = scan_order_q;
  assign cfg.fast    = extent_fast_q;
  assign cfg.stride0 = stride0_q;

  assign jump        = {jump_c2_i, jump_c1_i, jump_c0_i};
  assign cmd_ready_o = gen_ready;
  assign cmd_fire    = cmd_valid_i & gen_ready;

  // move the center on each command word
  kna_center u_center (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (cmd_fire),
    .op_i       (op_i),
    .jump_i     (jump),
    .cfg_i      (cfg),
    .center_o   (center),
    .end_flag_o (end_flag)
  );

  // walk the kernel offsets of the new center, one per cycle while results are taken
  kna_offset_gen u_offset_gen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_fire),
    .advance_i  (advance),
    .cfg_i      (cfg),
    .center_i   (center),
    .end_flag_i (end_flag),
    .ready_o    (gen_ready),
    .s1_valid_o (s1_valid),
    .s1_o       (s1)
  );

  // form the linear address and hold the result word
  kna_addr_out u_addr_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s1_valid_i       (s1_valid),
    .s1_i             (s1),
    .cfg_i            (cfg),
    .res_ready_i      (res_ready_i),
    .advance_o        (advance),
    .res_valid_o      (res_valid_o),
    .offset_number_o  (offset_number_o),
    .nb_o             (nb),
    .linear_address_o (linear_address_o),
    .at_end_o         (at_end_o),
    .last_o           (last_o)
  );

  assign neighbor_c0_o = nb[0];
  assign neighbor_c1_o = nb[1];
  assign neighbor_c2_o = nb[2];

  // an end marker is a lone word with every data field zero
  a_end_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && at_end_o |-> last_o && offset_number_o == '0 &&
                                linear_address_o == '0 && nb == '0)
    else $error("end marker carries data or is not last");

  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> offset_number_o <= OFS_W'(MAX_OFFSETS - 1))
    else $error("offset number past kernel size");

  a_jump_clears_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_fire && op_i == OP_JUMP |=> !end_flag)
    else $error("jump left end flag set");

  a_end_sets_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_fire && op_i == OP_END |=> end_flag)
    else $error("end command did not set end flag");

endmodule

@@ hdl/kna_center.sv @@
`timescale 1ns / 1ps
// Kernel center and end flag: applies one command per accepted word.
// Depends on kna_pkg.
module kna_center (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic [kna_pkg::OP_W-1:0]            op_i,
  input  kna_pkg::kna_coord_t                 jump_i,
  input  kna_pkg::kna_cfg_t                   cfg_i,
  output kna_pkg::kna_coord_t                 center_o,
  output logic                                end_flag_o
);
  import kna_pkg::*;

  kna_coord_t center_q, center_d;
  logic       end_q, end_d;

  always_comb begin
    logic       searching;
    logic       above;
    logic [1:0] d;
    center_d  = center_q;
    end_d     = end_q;
    searching = 1'b1;
    above     = 1'b0;
    d         = '0;
    if (accept_i) begin
      case (op_i)
        OP_FWD: begin
          if (!end_q) begin
            for (int ii = 0; ii < DIMS; ii++) begin
              d = scan_dim(cfg_i.scan, 2'(ii));
              if (searching) begin
                if (center_q[d] < cfg_i.hi[d]) begin
                  center_d[d] = center_q[d] + CW'(1);
                  searching   = 1'b0;
                end else begin
                  center_d[d] = cfg_i.lo[d];
                end
              end
            end
            // rolled over the slowest dimension: park at the high corner
            if (searching) begin
              end_d    = 1'b1;
              center_d = cfg_i.hi;
            end
          end
        end
        OP_BWD: begin
          if (end_q) begin
            end_d    = 1'b0;
            center_d = cfg_i.hi;
          end else begin
            for (int dd = 0; dd < DIMS; dd++) begin
              if (center_q[dd] > cfg_i.lo[dd]) above = 1'b1;
            end
            if (above) begin
              for (int ii = 0; ii < DIMS; ii++) begin
                d = scan_dim(cfg_i.scan, 2'(ii));
                if (searching) begin
                  if (center_q[d] > cfg_i.lo[d]) begin
                    center_d[d] = center_q[d] - CW'(1);
                    searching   = 1'b0;
                  end else begin
                    center_d[d] = cfg_i.hi[d];
                  end
                end
              end
            end
          end
        end
        OP_BEGIN: begin
          for (int dd = 0; dd < DIMS; dd++) begin
            center_d[dd] = (cfg_i.lo[dd] > cfg_i.hi[dd]) ? cfg_i.hi[dd] : cfg_i.lo[dd];
          end
          end_d = 1'b0;
        end
        OP_END: begin
          center_d = cfg_i.hi;
          end_d    = 1'b1;
        end
        OP_JUMP: begin
          for (int dd = 0; dd < DIMS; dd++) begin
            center_d[dd] = (jump_i[dd] < cfg_i.lo[dd]) ? cfg_i.lo[dd] : jump_i[dd];
            if (center_d[dd] > cfg_i.hi[dd]) center_d[dd] = cfg_i.hi[dd];
          end
          end_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      end_q    <= 1'b0;
    end else begin
      center_q <= center_d;
      end_q    <= end_d;
    end
  end

  assign center_o   = center_q;
  assign end_flag_o = end_q;

endmodule

@@ hdl/kna_offset_gen.sv @@
`timescale 1ns / 1ps
// Offset walker: steps offsets one per cycle unless stalled; clamps each neighbor.
// Depends on kna_pkg; feeds kna_addr_out through a registered stage.
module kna_offset_gen (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 advance_i,
  input  kna_pkg::kna_cfg_t    cfg_i,
  input  kna_pkg::kna_coord_t  center_i,
  input  logic                 end_flag_i,
  output logic                 ready_o,
  output logic                 s1_valid_o,
  output kna_pkg::kna_res_t    s1_o
);
  import kna_pkg::*;

  logic                        busy_q, busy_d;
  logic [DIMS-1:0][1:0]        off_q, off_d;   // two's complement -1..1
  logic [DIMS-1:0][1:0]        kmin, kmax;
  logic [DIMS-1:0]             at_max;
  logic [OFS_W-1:0]            k_q, k_d;
  logic                        fire, last_now;
  kna_res_t                    res;
  logic                        s1_valid_q;
  kna_res_t                    s1_q;

  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      kmin[d]   = cfg_i.back[d] ? 2'b11 : 2'b00;
      kmax[d]   = cfg_i.fwd[d]  ? 2'b01 : 2'b00;
      at_max[d] = (off_q[d] == kmax[d]);
    end
  end

  assign fire     = busy_q & advance_i;
  assign last_now = end_flag_i | (&at_max);
  assign ready_o  = ~busy_q | (fire & last_now);

  // clamp center plus offset into the region
  always_comb begin
    logic signed [CW+1:0] v, lo_s, hi_s, t;
    v = '0; lo_s = '0; hi_s = '0; t = '0;
    res.k      = end_flag_i ? '0 : k_q;
    res.at_end = end_flag_i;
    res.last   = last_now;
    for (int d = 0; d < DIMS; d++) begin
      v    = $signed({2'b00, center_i[d]}) + $signed({{CW{off_q[d][1]}}, off_q[d]});
      lo_s = $signed({2'b00, cfg_i.lo[d]});
      hi_s = $signed({2'b00, cfg_i.hi[d]});
      t    = (v < lo_s) ? lo_s : v;
      t    = (t > hi_s) ? hi_s : t;
      res.nb[d] = end_flag_i ? '0 : t[CW-1:0];
    end
  end

  // advance offsets, dimension 2 fastest
  always_comb begin
    logic carry;
    carry  = 1'b1;
    busy_d = busy_q;
    off_d  = off_q;
    k_d    = k_q;
    if (start_i) begin
      busy_d = 1'b1;
      off_d  = kmin;
      k_d    = '0;
    end else if (fire) begin
      if (last_now) begin
        busy_d = 1'b0;
      end else begin
        k_d = k_q + OFS_W'(1);
        for (int d = DIMS - 1; d >= 0; d--) begin
          if (carry) begin
            if (at_max[d]) begin
              off_d[d] = kmin[d];
            end else begin
              off_d[d] = off_q[d] + 2'b01;
              carry    = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (advance_i) s1_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d;
    k_q   <= k_d;
    if (advance_i) s1_q <= res;
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

endmodule

@@ hdl/kna_addr_out.sv @@
`timescale 1ns / 1ps
// Linear address multiply-add and the result register.
// Depends on kna_pkg.
module kna_addr_out (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s1_valid_i,
  input  kna_pkg::kna_res_t                  s1_i,
  input  kna_pkg::kna_cfg_t                  cfg_i,
  input  logic                               res_ready_i,
  output logic                               advance_o,
  output logic                               res_valid_o,
  output logic [kna_pkg::OFS_W-1:0]          offset_number_o,
  output kna_pkg::kna_coord_t                nb_o,
  output logic [kna_pkg::ADDR_W-1:0]         linear_address_o,
  output logic                               at_end_o,
  output logic                               last_o
);
  import kna_pkg::*;

  logic [CW+STRIDE_W-1:0] p0;
  logic [CW+EXT_W-1:0]    p1;
  logic [ADDR_W-1:0]      addr;
  logic                   valid_q;
  kna_res_t               res_q;
  logic [ADDR_W-1:0]      addr_q;

  assign p0   = s1_i.nb[0] * cfg_i.stride0;
  assign p1   = s1_i.nb[1] * cfg_i.fast;
  assign addr = p0[ADDR_W-1:0] + ADDR_W'(p1) + ADDR_W'(s1_i.nb[2]);

  // hold the word until taken
  assign advance_o = ~valid_q | res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && s1_valid_i) begin
      res_q  <= s1_i;
      addr_q <= addr;
    end
  end

  assign res_valid_o      = valid_q;
  assign offset_number_o  = res_q.k;
  assign nb_o             = res_q.nb;
  assign linear_address_o = addr_q;
  assign at_end_o         = res_q.at_end;
  assign last_o           = res_q.last;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for kernel_neighborhood_address_gen: directed and random move
// commands against an in-bench model of center movement and neighborhood emission.
// Depends on kna_pkg and the block under hdl.
module testbench;
  import kna_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int PHASES       = 10;
  localparam int PHASE_CMDS   = 15;
  // op codes the block does not define; a command with one of these must not move
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [OP_W-1:0] op;
    kna_coord_t      target;
  } move_cmd_t;

  typedef struct {
    logic [OFS_W-1:0]  ofs;
    kna_coord_t        nb;
    logic [ADDR_W-1:0] addr;
    logic              at_end;
    logic              last;
  } nb_word_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_ready;
  logic [OP_W-1:0]       op        = '0;
  logic [CW-1:0]         jump_c0   = '0;
  logic [CW-1:0]         jump_c1   = '0;
  logic [CW-1:0]         jump_c2   = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  logic [OFS_W-1:0]      offset_number;
  logic [CW-1:0]         neighbor_c0;
  logic [CW-1:0]         neighbor_c1;
  logic [CW-1:0]         neighbor_c2;
  logic [ADDR_W-1:0]     linear_address;
  logic                  at_end;
  logic                  last;

  initial begin
    forever #5 clk = ~clk;
  end

  kernel_neighborhood_address_gen u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .cmd_valid_i      (cmd_valid),
    .cmd_ready_o      (cmd_ready),
    .op_i             (op),
    .jump_c0_i        (jump_c0),
    .jump_c1_i        (jump_c1),
    .jump_c2_i        (jump_c2),
    .res_valid_o      (res_valid),
    .res_ready_i      (res_ready),
    .offset_number_o  (offset_number),
    .neighbor_c0_o    (neighbor_c0),
    .neighbor_c1_o    (neighbor_c1),
    .neighbor_c2_o    (neighbor_c2),
    .linear_address_o (linear_address),
    .at_end_o         (at_end),
    .last_o           (last)
  );

  // ---------------------------------------------------------------------------
  // Model copy of the configuration and the walker state, at reset values.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]  roi_lo    = '0;
  logic [CFG_W-1:0]  roi_hi    = '0;
  logic [EXT_W-1:0]  ext_mid   = 17'd1;
  logic [EXT_W-1:0]  ext_fast  = 17'd1;
  logic [DIMS-1:0]   back_mask = '0;
  logic [DIMS-1:0]   fwd_mask  = '0;
  logic [2:0]        scan_code = '0;
  kna_coord_t        center    = '0;
  logic              past_end  = 1'b0;

  move_cmd_t   pending_cmds [$];   // command words not yet offered to the block
  move_cmd_t   cmd_shown;          // command word currently on the command port
  nb_word_t    expected_words [$]; // neighbor words predicted but not yet seen
  nb_word_t    due_word;
  int          errors        = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int unsigned cycle_count   = 0;

  function automatic int bound_lo(int d);
    return int'(roi_lo[16*d +: 16]);
  endfunction

  function automatic int bound_hi(int d);
    return int'(roi_hi[16*d +: 16]);
  endfunction

  // Low bound first, high bound last: an inverted range lands on the high bound.
  function automatic int clamp_roi(int d, int v);
    if (v < bound_lo(d)) v = bound_lo(d);
    if (v > bound_hi(d)) v = bound_hi(d);
    return v;
  endfunction

  // Dimension stepped at scan position pos, position 0 fastest.
  // The two spare codes fall back to the default order.
  function automatic int scan_dim_at(logic [2:0] code, int pos);
    int order [3];
    case (code)
      SCAN_201: order = '{2, 0, 1};
      SCAN_120: order = '{1, 2, 0};
      SCAN_102: order = '{1, 0, 2};
      SCAN_021: order = '{0, 2, 1};
      SCAN_012: order = '{0, 1, 2};
      default:  order = '{2, 1, 0};
    endcase
    return order[pos];
  endfunction

  function automatic void center_to_high();
    for (int d = 0; d < DIMS; d++) center[d] = 16'(clamp_roi(d, bound_hi(d)));
  endfunction

  // Forward step: roll over each exhausted dimension to its low bound; running off
  // the slowest dimension parks the center on the high corner and sets the end flag.
  function automatic void step_ahead();
    int d;
    if (past_end) return;
    for (int i = 0; i < DIMS; i++) begin
      d = scan_dim_at(scan_code, i);
      if (int'(center[d]) < bound_hi(d)) begin
        center[d] = center[d] + 16'd1;
        return;
      end else if (i != DIMS - 1) begin
        center[d] = 16'(bound_lo(d));
      end else begin
        past_end = 1'b1;
        center_to_high();
        return;
      end
    end
  endfunction

  // Backward step: leave the end state onto the high corner, hold at the begin,
  // otherwise decrement the first dimension above its low bound.
  function automatic void step_back();
    int  d;
    bit  at_begin;
    if (past_end) begin
      past_end = 1'b0;
      center_to_high();
      return;
    end
    at_begin = 1'b1;
    for (int i = 0; i < DIMS; i++)
      if (int'(center[i]) > bound_lo(i)) at_begin = 1'b0;
    if (at_begin) return;
    for (int i = 0; i < DIMS; i++) begin
      d = scan_dim_at(scan_code, i);
      if (int'(center[d]) > bound_lo(d)) begin
        center[d] = center[d] - 16'd1;
        return;
      end else if (i != DIMS - 1) begin
        center[d] = 16'(bound_hi(d));
      end
    end
  endfunction

  // Move the center for one command word and queue the neighbor words it causes.
  function automatic void predict_neighborhood(move_cmd_t c);
    int          kmin [DIMS];
    int          span [DIMS];
    int          nb_i [DIMS];
    int          count;
    int          rem;
    int          off;
    logic [63:0] stride0;
    logic [63:0] addr_sum;
    nb_word_t    w;

    case (c.op)
      OP_FWD:   step_ahead();
      OP_BWD:   step_back();
      OP_BEGIN: begin
        for (int d = 0; d < DIMS; d++) center[d] = 16'(clamp_roi(d, bound_lo(d)));
        past_end = 1'b0;
      end
      OP_END: begin
        center_to_high();
        past_end = 1'b1;
      end
      OP_JUMP: begin
        for (int d = 0; d < DIMS; d++) center[d] = 16'(clamp_roi(d, int'(c.target[d])));
        past_end = 1'b0;
      end
      default: ;
    endcase

    if (past_end) begin
      w.ofs    = '0;
      w.nb     = '0;
      w.addr   = '0;
      w.at_end = 1'b1;
      w.last   = 1'b1;
      expected_words.push_back(w);
      return;
    end

    stride0 = (64'(ext_mid) * 64'(ext_fast)) & 64'hFFFF_FFFF_FFFF;
    count = 1;
    for (int d = 0; d < DIMS; d++) begin
      kmin[d] = -int'(back_mask[d]);
      span[d] = int'(fwd_mask[d]) - kmin[d] + 1;
      count   = count * span[d];
    end
    if (count > MAX_OFFSETS) count = MAX_OFFSETS;

    // offsets enumerate with dimension 2 fastest
    for (int k = 0; k < count; k++) begin
      rem = k;
      for (int d = DIMS - 1; d >= 0; d--) begin
        off     = kmin[d] + rem % span[d];
        rem     = rem / span[d];
        nb_i[d] = clamp_roi(d, int'(center[d]) + off);
      end
      addr_sum = 64'(nb_i[0]) * stride0 + 64'(nb_i[1]) * 64'(ext_fast) + 64'(nb_i[2]);
      w.ofs    = 5'(k);
      for (int d = 0; d < DIMS; d++) w.nb[d] = 16'(nb_i[d]);
      w.addr   = addr_sum[ADDR_W-1:0];
      w.at_end = 1'b0;
      w.last   = (k == count - 1);
      expected_words.push_back(w);
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver: predict on acceptance, then offer the next pending word or
  // idle. Hold valid and payload while a word waits for ready.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) predict_neighborhood(cmd_shown);
      if (!cmd_valid || cmd_ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cmd_shown = pending_cmds.pop_front();
          cmd_valid <= 1'b1;
          op        <= cmd_shown.op;
          jump_c0   <= cmd_shown.target[0];
          jump_c1   <= cmd_shown.target[1];
          jump_c2   <= cmd_shown.target[2];
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare every accepted word with the oldest prediction,
  // then pick the next ready at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none got ofs %0h nb %0h/%0h/%0h addr %0h",
                   $time, offset_number, neighbor_c0, neighbor_c1, neighbor_c2,
                   linear_address);
          errors++;
        end else begin
          due_word = expected_words.pop_front();
          check_field("offset_number", 64'(due_word.ofs), 64'(offset_number));
          check_field("neighbor_c0", 64'(due_word.nb[0]), 64'(neighbor_c0));
          check_field("neighbor_c1", 64'(due_word.nb[1]), 64'(neighbor_c1));
          check_field("neighbor_c2", 64'(due_word.nb[2]), 64'(neighbor_c2));
          check_field("linear_address", 64'(due_word.addr), 64'(linear_address));
          check_field("at_end", 64'(due_word.at_end), 64'(at_end));
          check_field("last", 64'(due_word.last), 64'(last));
        end
      end
      res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  // Drive one register write and mirror it in the model copy as the write is driven.
  task automatic write_reg(kna_reg_e idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_ROI_LOW:     roi_lo    = data;
      REG_ROI_HIGH:    roi_hi    = data;
      REG_EXTENT_MID:  ext_mid   = data[EXT_W-1:0];
      REG_EXTENT_FAST: ext_fast  = data[EXT_W-1:0];
      REG_WINDOW_BACK: back_mask = data[DIMS-1:0];
      REG_WINDOW_FWD:  fwd_mask  = data[DIMS-1:0];
      REG_SCAN_ORDER:  scan_code = data[2:0];
      default: ;
    endcase
  endtask

  // Rewrite every register, drop the write enable, and settle on a falling edge
  // so that queue updates never race the clocked blocks.
  task automatic load_config(kna_coord_t lo, kna_coord_t hi, logic [EXT_W-1:0] mid,
                             logic [EXT_W-1:0] fast, logic [2:0] back, logic [2:0] fwd,
                             logic [2:0] scan);
    write_reg(REG_ROI_LOW, CFG_W'(lo));
    write_reg(REG_ROI_HIGH, CFG_W'(hi));
    write_reg(REG_EXTENT_MID, CFG_W'(mid));
    write_reg(REG_EXTENT_FAST, CFG_W'(fast));
    write_reg(REG_WINDOW_BACK, CFG_W'(back));
    write_reg(REG_WINDOW_FWD, CFG_W'(fwd));
    write_reg(REG_SCAN_ORDER, CFG_W'(scan));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_cmd(logic [OP_W-1:0] code, logic [CW-1:0] c0, logic [CW-1:0] c1,
                           logic [CW-1:0] c2);
    move_cmd_t c;
    c.op        = code;
    c.target[0] = c0;
    c.target[1] = c1;
    c.target[2] = c2;
    pending_cmds.push_back(c);
  endtask

  // Mostly steps so the center walks through rollovers and into the end state;
  // the rest are begin/end/jump and a few spare op codes.
  function automatic move_cmd_t random_cmd(bit step_only);
    move_cmd_t c;
    int        pick;
    pick = $urandom_range(0, 99);
    if (step_only) pick = pick % 70;
    if (pick < 45)      c.op = OP_FWD;
    else if (pick < 70) c.op = OP_BWD;
    else if (pick < 77) c.op = OP_BEGIN;
    else if (pick < 84) c.op = OP_END;
    else if (pick < 95) c.op = OP_JUMP;
    else                c.op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    for (int d = 0; d < DIMS; d++) begin
      if ($urandom_range(0, 1) != 0) c.target[d] = 16'($urandom);
      else c.target[d] = 16'(bound_lo(d) + $urandom_range(0, 4) - 1);
    end
    return c;
  endfunction

  // Hold until every command word is taken and every predicted word has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || cmd_valid || expected_words.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    kna_coord_t       lo;
    kna_coord_t       hi;
    logic [EXT_W-1:0] mid;
    logic [EXT_W-1:0] fast;
    logic [2:0]       back;
    logic [2:0]       fwd;
    int               v;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: 2x2x2 region, full 3x3x3 kernel, widest extents.
    send_idle_pct = 37;
    recv_idle_pct = 85;
    load_config({16'd3, 16'd1, 16'd2}, {16'd3, 16'd1, 16'd2} & '0 | {16'd3, 16'd1, 16'd2},
                17'h10000, 17'h10000, 3'b111, 3'b111, SCAN_210);
    // low corner (1,0,2), high corner (2,1,3)
    load_config({16'd2, 16'd0, 16'd1}, {16'd3, 16'd1, 16'd2},
                17'h10000, 17'h10000, 3'b111, 3'b111, SCAN_210);
    queue_cmd(OP_BEGIN, 16'h0000, 16'h0000, 16'h0000);
    // walk all eight centers; the eighth step runs past the end
    repeat (8) queue_cmd(OP_FWD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_cmd(OP_FWD, 16'h0000, 16'h0000, 16'h0000);   // forward while at end
    queue_cmd(OP_BWD, 16'h0000, 16'h0000, 16'h0000);   // leave end onto last element
    queue_cmd(OP_JUMP, 16'h0000, 16'h0000, 16'h0000);  // clamps up to the low corner
    queue_cmd(OP_BWD, 16'hFFFF, 16'hFFFF, 16'hFFFF);   // backward at begin holds
    queue_cmd(OP_JUMP, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // clamps down to the high corner
    queue_cmd(OP_END, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(OP_JUMP, 16'd1 + 16'd1, 16'd1, 16'd3);   // onto the center itself
    for (int s = OP_SPARE_LO; s <= OP_SPARE_HI; s++)
      queue_cmd(OP_W'(s), 16'hA5A5, 16'h5A5A, 16'hFFFF);
    queue_cmd(OP_BWD, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(OP_BWD, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(OP_FWD, 16'h0000, 16'h0000, 16'h0000);
    wait_drained();

    // Random phases; the center carries over, so a phase may open off-region.
    for (int p = 1; p <= PHASES; p++) begin
      if (p == 4) begin
        send_idle_pct = 85;
        recv_idle_pct = 37;
      end else if (p == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int d = 0; d < DIMS; d++) begin
        if ($urandom_range(0, 3) == 0) v = 65535 - $urandom_range(0, 2);
        else v = $urandom_range(0, 65535);
        lo[d] = 16'(v);
        v = v + $urandom_range(0, 2);
        hi[d] = (v > 65535) ? 16'hFFFF : 16'(v);
      end
      mid  = ($urandom_range(0, 3) == 0) ? 17'h10000 : 17'($urandom_range(1, 65536));
      fast = ($urandom_range(0, 3) == 0) ? 17'h10000 : 17'($urandom_range(1, 65536));
      back = 3'($urandom_range(0, 7));
      fwd  = 3'($urandom_range(0, 7));
      if (p == 1) begin
        // whole coordinate space, unit extents, single-offset kernel
        lo   = '0;
        hi   = '1;
        mid  = 17'd1;
        fast = 17'd1;
        back = '0;
        fwd  = '0;
      end else if (p == 2) begin
        // invert dimension 1 so clamping lands on the upper bound
        hi[1] = 16'($urandom_range(0, 65000));
        lo[1] = hi[1] + 16'($urandom_range(1, 5));
      end
      // cycle through every scan code, the two spare ones included
      load_config(lo, hi, mid, fast, back, fwd, 3'(p));
      for (int i = 0; i < PHASE_CMDS; i++) pending_cmds.push_back(random_cmd(i == 0));
      wait_drained();
    end

    // let any stray word show up before the verdict
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: count cycles and end the run if it hangs.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/kna_pkg.sv
hdl/kna_center.sv
hdl/kna_offset_gen.sv
hdl/kna_addr_out.sv
hdl/kernel_neighborhood_address_gen.sv
tb/testbench.sv
